// ----- rtl/alarm_compare_timer_macros.svh -----
// Assertion macros shared by the alarm compare timer RTL.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef ALARM_COMPARE_TIMER_MACROS_SVH
`define ALARM_COMPARE_TIMER_MACROS_SVH

`define ACMT_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`define ACMT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/acmt_pkg.sv -----
// Package for the alarm compare timer: widths, codes and shared structs.
// Used by every module of the block; depends on nothing.
package acmt_pkg;

  localparam int CHANNELS    = 4;
  localparam int COUNT_WIDTH = 32;
  localparam int CH_W        = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int BIT_W       = $clog2(COUNT_WIDTH);
  localparam logic [31:0] COUNT_MASK = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  localparam logic [1:0] REG_TOP    = 2'd0;
  localparam logic [1:0] REG_GUARD  = 2'd1;
  localparam logic [1:0] REG_DIV    = 2'd2;
  localparam logic [1:0] REG_TOP_EN = 2'd3;

  typedef enum logic [2:0] {
    K_TICK   = 3'd0,
    K_ARM    = 3'd1,
    K_CANCEL = 3'd2,
    K_START  = 3'd3,
    K_STOP   = 3'd4,
    K_WRITE  = 3'd5
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_BUSY    = 2'd2,
    ST_LATE    = 2'd3
  } status_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] top;
    logic [31:0]            guard;
    logic [15:0]            div;
    logic                   top_en;
    logic                   top_wr;
  } cfg_t;

  typedef struct packed {
    logic                   valid;
    logic [COUNT_WIDTH-1:0] value;
  } red_t;

endpackage

// ----- rtl/acmt_regs.sv -----
// Configuration register file of the alarm compare timer, on an APB-style port.
// Depends on acmt_pkg; presents the effective settings to the rest of the block.
module acmt_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output acmt_pkg::cfg_t      cfg
);
  import acmt_pkg::*;

  logic [31:0] top_value;
  logic [31:0] guard_ticks;
  logic [15:0] prescale_divider;
  logic        top_event_enable;
  logic        top_wr;
  logic        wr;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      top_value        <= 32'hFFFF_FFFF;
      guard_ticks      <= '0;
      prescale_divider <= '0;
      top_event_enable <= 1'b0;
      top_wr           <= 1'b0;
    end else begin
      top_wr <= 1'b0;
      if (wr) begin
        case (paddr[3:2])
          REG_TOP: begin
            top_value <= pwdata;
            top_wr    <= 1'b1;
          end
          REG_GUARD:  guard_ticks      <= pwdata;
          REG_DIV:    prescale_divider <= pwdata[15:0];
          REG_TOP_EN: top_event_enable <= pwdata[0];
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_TOP:    prdata = top_value;
      REG_GUARD:  prdata = guard_ticks;
      REG_DIV:    prdata = {16'd0, prescale_divider};
      REG_TOP_EN: prdata = {31'd0, top_event_enable};
      default:    prdata = '0;
    endcase
  end

  assign cfg.top    = (top_value > COUNT_MASK) ? COUNT_MASK[COUNT_WIDTH-1:0]
                                               : top_value[COUNT_WIDTH-1:0];
  assign cfg.guard  = guard_ticks;
  assign cfg.div    = prescale_divider;
  assign cfg.top_en = top_event_enable;
  assign cfg.top_wr = top_wr;

endmodule

// ----- rtl/acmt_reduce.sv -----
// Bit-serial remainder unit: count modulo (top + 1), one dividend bit a cycle.
// Depends on acmt_pkg; restarts whenever the count or the top value is rewritten.
module acmt_reduce (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [acmt_pkg::COUNT_WIDTH-1:0] count,
  input  logic [acmt_pkg::COUNT_WIDTH-1:0] top,
  input  logic                          inval,
  output acmt_pkg::red_t                red
);
  import acmt_pkg::*;

  logic                   active;
  logic                   done;
  logic [BIT_W-1:0]       idx;
  logic [COUNT_WIDTH:0]   rem;
  logic [COUNT_WIDTH:0]   modulus;
  logic [COUNT_WIDTH+1:0] cand;
  logic [COUNT_WIDTH+1:0] diff;
  logic [COUNT_WIDTH:0]   rem_next;
  logic                   need;

  assign modulus = {1'b0, top} + {{COUNT_WIDTH{1'b0}}, 1'b1};
  assign need    = count > top;
  assign cand    = {rem, count[idx]};
  assign diff    = cand - {1'b0, modulus};
  assign rem_next = diff[COUNT_WIDTH+1] ? cand[COUNT_WIDTH:0] : diff[COUNT_WIDTH:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
      idx    <= '0;
    end else if (inval) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else if (active) begin
      idx <= idx - BIT_W'(1);
      if (idx == '0) begin
        active <= 1'b0;
        done   <= 1'b1;
      end
    end else if (!done && need) begin
      active <= 1'b1;
      idx    <= BIT_W'(COUNT_WIDTH - 1);
    end
  end

  // The remainder is held once complete, for as long as the stalled item waits.
  always_ff @(posedge clk) begin
    if (active) begin
      rem <= rem_next;
    end else if (!done) begin
      rem <= '0;
    end
  end

  assign red.valid = done;
  assign red.value = rem[COUNT_WIDTH-1:0];

endmodule

// ----- rtl/acmt_core.sv -----
// Timer state, input register, single-pass item logic and result register.
// Depends on acmt_pkg, the configuration struct and the remainder unit's result.
module acmt_core (
  input  logic                             clk,
  input  logic                             rst,
  input  acmt_pkg::cfg_t                   cfg,
  input  acmt_pkg::red_t                   red,
  output logic [acmt_pkg::COUNT_WIDTH-1:0] count,
  output logic                             count_wr,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic [2:0]                       kind,
  input  logic [1:0]                       channel,
  input  logic [31:0]                      value,
  input  logic                             absolute,
  input  logic                             expire_when_late,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [1:0]                       status,
  output logic [31:0]                      count_now,
  output logic [3:0]                       alarm_fired,
  output logic                             top_event
);
  import acmt_pkg::*;

  localparam int CW = COUNT_WIDTH;

  logic          s1_valid;
  logic [2:0]    s1_kind;
  logic [1:0]    s1_ch;
  logic [31:0]   s1_value;
  logic          s1_abs;
  logic          s1_expire;
  logic          s1_adv;
  logic          red_ok;

  logic [15:0]          prescale_count;
  logic                 running;
  logic [CHANNELS-1:0]  armed;
  logic [CW-1:0]        match_value [CHANNELS];

  logic [CW-1:0]        count_next;
  logic [15:0]          prescale_count_next;
  logic                 running_next;
  logic [CHANNELS-1:0]  armed_next;
  logic                 cmp_we;
  logic [CW-1:0]        cmp_wdata;
  status_t              status_c;
  logic [3:0]           fired_c;
  logic                 top_c;

  logic [CW-1:0]        st_count;
  status_t              st_status;
  logic [3:0]           st_fired;
  logic                 st_top;

  logic [CH_W-1:0]      ch_idx;
  logic [CW-1:0]        cr;
  logic [CW:0]          modulus;
  logic [CW:0]          sum;
  logic [CW:0]          placed;
  logic [CW-1:0]        valc;
  logic [CW-1:0]        valp;
  logic [CW-1:0]        vm1;
  logic [CW:0]          diff_w;
  logic [CW-1:0]        diff;
  logic [CW-1:0]        half;
  logic                 short_rel;
  logic [CW-1:0]        limit;
  logic                 fire_late;

  assign red_ok   = (count <= cfg.top) || red.valid;
  assign s1_adv   = s1_valid && (!out_valid || out_ready) && red_ok;
  assign in_ready = !s1_valid || s1_adv;
  assign count_wr = s1_adv && (s1_kind == K_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_kind   <= kind;
      s1_ch     <= channel;
      s1_value  <= value;
      s1_abs    <= absolute;
      s1_expire <= expire_when_late;
    end
  end

  // Arm placement and late detection, all in modulo (top + 1) arithmetic.
  // For a relative alarm the distance ahead reduces to the requested ticks less one.
  assign ch_idx    = s1_ch[CH_W-1:0];
  assign cr        = (count > cfg.top) ? red.value : count;
  assign modulus   = {1'b0, cfg.top} + {{CW{1'b0}}, 1'b1};
  assign valc      = s1_value[CW-1:0];
  assign sum       = {1'b0, cr} + {1'b0, valc};
  assign placed    = (sum >= modulus) ? (sum - modulus) : sum;
  assign valp      = s1_abs ? valc : placed[CW-1:0];
  assign vm1       = (valc == '0) ? cfg.top : (valc - CW'(1));
  assign diff_w    = (vm1 >= cr) ? {1'b0, vm1 - cr}
                                 : ({1'b0, vm1} + modulus - {1'b0, cr});
  assign diff      = s1_abs ? diff_w[CW-1:0] : vm1;
  assign half      = cfg.top >> 1;
  assign short_rel = valc < half;
  assign fire_late = s1_abs ? s1_expire : short_rel;

  always_comb begin
    if (s1_abs) begin
      limit = ({{(32-CW){1'b0}}, cfg.top} <= cfg.guard) ? '0
                                                         : (cfg.top - cfg.guard[CW-1:0]);
    end else begin
      limit = short_rel ? half : cfg.top;
    end
  end

  always_comb begin
    count_next          = count;
    prescale_count_next = prescale_count;
    running_next        = running;
    armed_next          = armed;
    cmp_we              = 1'b0;
    cmp_wdata           = valp;
    status_c            = ST_OK;
    fired_c             = '0;
    top_c               = 1'b0;
    case (kind_t'(s1_kind))
      K_TICK: begin
        if (running) begin
          if (prescale_count >= cfg.div) begin
            prescale_count_next = '0;
            if (count >= cfg.top) begin
              count_next = '0;
              top_c      = cfg.top_en;
            end else begin
              count_next = count + CW'(1);
            end
            for (int i = 0; i < CHANNELS; i++) begin
              if (armed[i] && (match_value[i] == count_next)) begin
                armed_next[i] = 1'b0;
                fired_c[i]    = 1'b1;
              end
            end
          end else begin
            prescale_count_next = prescale_count + 16'd1;
          end
        end
      end
      K_ARM: begin
        if ((int'(s1_ch) >= CHANNELS) || (s1_value > {{(32-CW){1'b0}}, cfg.top})) begin
          status_c = ST_INVALID;
        end else if (armed[ch_idx]) begin
          status_c = ST_BUSY;
        end else begin
          cmp_we = 1'b1;
          if (diff > limit) begin
            armed_next[ch_idx] = 1'b0;
            fired_c[ch_idx]    = fire_late;
            status_c           = s1_abs ? ST_LATE : ST_OK;
          end else begin
            armed_next[ch_idx] = 1'b1;
          end
        end
      end
      K_CANCEL: begin
        if (int'(s1_ch) < CHANNELS) begin
          armed_next[ch_idx] = 1'b0;
        end
      end
      K_START: running_next = 1'b1;
      K_STOP:  running_next = 1'b0;
      K_WRITE: count_next = valc;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count          <= '0;
      prescale_count <= '0;
      running        <= 1'b0;
      armed          <= '0;
    end else if (s1_adv) begin
      count          <= count_next;
      prescale_count <= prescale_count_next;
      running        <= running_next;
      armed          <= armed_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        match_value[i] <= '0;
      end
    end else if (s1_adv && cmp_we) begin
      match_value[ch_idx] <= cmp_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      st_count  <= count_next;
      st_status <= status_c;
      st_fired  <= fired_c;
      st_top    <= top_c;
    end
  end

  assign status      = st_status;
  assign count_now   = 32'(st_count);
  assign alarm_fired = st_fired;
  assign top_event   = st_top;

  `include "alarm_compare_timer_macros.svh"

  `ACMT_ASSERT_NEXT(a_status_only_on_arm, s1_adv && (s1_kind != K_ARM), st_status == ST_OK, "non-arm status")
  `ACMT_ASSERT_NEXT(a_fired_disarmed, s1_adv, (armed & st_fired[CHANNELS-1:0]) == '0, "fired but armed")
  `ACMT_ASSERT_NOW(a_wrap_count_zero, out_valid && st_top, st_count == '0, "top event, count not zero")
  `ACMT_ASSERT_NOW(a_no_advance_unreduced, !red_ok, !s1_adv, "item taken before reduction")

endmodule

// ----- rtl/alarm_compare_timer.sv -----
// Alarm compare timer. One item per cycle while the result is taken and no reduction is pending.
// Items pass an input register and the single-pass timer logic into a result register.
// After a count write above top, or a top write with the count above top, the input stalls
// while the bit-serial remainder unit reduces the count.
// Synchronous active-high reset: count, prescaler and alarms clear, timer stopped,
// registers to their reset values.
module alarm_compare_timer (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  kind,
  input  logic [1:0]  channel,
  input  logic [31:0] value,
  input  logic        absolute,
  input  logic        expire_when_late,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [31:0] count_now,
  output logic [3:0]  alarm_fired,
  output logic        top_event
);
  import acmt_pkg::*;

  cfg_t                   cfg;
  red_t                   red;
  logic [COUNT_WIDTH-1:0] count;
  logic                   count_wr;

  acmt_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  acmt_reduce u_reduce (
    .clk   (clk),
    .rst   (rst),
    .count (count),
    .top   (cfg.top),
    .inval (count_wr || cfg.top_wr),
    .red   (red)
  );

  acmt_core u_core (
    .clk              (clk),
    .rst              (rst),
    .cfg              (cfg),
    .red              (red),
    .count            (count),
    .count_wr         (count_wr),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .kind             (kind),
    .channel          (channel),
    .value            (value),
    .absolute         (absolute),
    .expire_when_late (expire_when_late),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .count_now        (count_now),
    .alarm_fired      (alarm_fired),
    .top_event        (top_event)
  );

endmodule
